[src/cpdc_pkg.sv]
// shared types, widths and register codes for the cylinder distance block
package cpdc_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int COORD_WIDTH    = 32;
  localparam int AXIS_WIDTH     = 18;
  localparam int LEN_WIDTH      = 31;
  localparam int DIST_WIDTH     = 32;
  localparam int REG_ADDR_WIDTH = 5;
  localparam int REG_DATA_WIDTH = 32;

  // datapath widths that follow from the field widths
  localparam int V_W     = COORD_WIDTH + 1;           // point minus base
  localparam int P_W     = V_W + AXIS_WIDTH;          // one axial product
  localparam int D1_W    = P_W + 2 - FRAC_BITS;       // axial distance
  localparam int Q_W     = D1_W + AXIS_WIDTH;         // projection product
  localparam int R_W     = Q_W - FRAC_BITS + 1;       // radial component
  localparam int RH_W    = R_W / 2;                   // half of a radial magnitude
  localparam int SQ1_W   = 2 * R_W;                   // one radial square
  localparam int RSQ_W   = SQ1_W + 2;                 // sum of radial squares
  localparam int PD_W    = D1_W + 1;                  // cap distances
  localparam int SQ_WIDTH = 2 * DIST_WIDTH;           // square root radicand
  localparam int CYL_W   = DIST_WIDTH + 2;            // radial excess

  typedef enum logic [2:0] {
    REG_BASE_X     = 3'd0,
    REG_BASE_Y     = 3'd1,
    REG_BASE_Z     = 3'd2,
    REG_AXIS_X     = 3'd3,
    REG_AXIS_Y     = 3'd4,
    REG_AXIS_Z     = 3'd5,
    REG_CYL_RADIUS = 3'd6,
    REG_CYL_HEIGHT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] base_x;
    logic signed [COORD_WIDTH-1:0] base_y;
    logic signed [COORD_WIDTH-1:0] base_z;
    logic signed [AXIS_WIDTH-1:0]  axis_x;
    logic signed [AXIS_WIDTH-1:0]  axis_y;
    logic signed [AXIS_WIDTH-1:0]  axis_z;
    logic [LEN_WIDTH-1:0]          cyl_radius;
    logic [LEN_WIDTH-1:0]          cyl_height;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic [LEN_WIDTH-1:0]          half_thick;
  } in_item_t;

  typedef struct packed {
    logic signed [DIST_WIDTH-1:0] signed_dist;
    logic                         is_inside;
    logic                         is_outside;
    logic                         is_boundary;
  } out_item_t;

  // status carried alongside the radial square root
  typedef struct packed {
    logic signed [PD_W-1:0] pd;
    logic                   inner;
    logic                   outside;
  } front_side_t;

  // status carried alongside the rim square root
  typedef struct packed {
    logic                         rim;
    logic signed [DIST_WIDTH-1:0] mx;
    logic                         inner;
    logic                         outside;
  } rim_side_t;

endpackage

[src/cylinder_point_distance_classify.sv]
// top level: capped cylinder signed distance and band classification
//
// One query point is taken in every clock cycle (busy never rises) and its
// result appears at the end of the pipeline as a one-cycle done strobe; there is no
// back pressure, so the receiver must take each result when it is shown.
// The pipeline is made mostly of the two 32-stage square-root pipelines (radial
// length and rim distance), plus the front stages of products and sums before the
// first root, the rim selection stages between the roots and one output register.
// The user must write configuration through the apb-style port only while no
// query is in flight; the block itself does not enforce this.
module cylinder_point_distance_classify import cpdc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  in_item_t                  query,
  output logic                      done,
  output out_item_t                 result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [REG_ADDR_WIDTH-1:0] paddr,
  input  logic [REG_DATA_WIDTH-1:0] pwdata,
  output logic [REG_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  localparam logic [DIST_WIDTH-1:0] DMAX = {1'b0, {(DIST_WIDTH-1){1'b1}}};

  cfg_t                      cfg;
  logic                      f_valid, s1_valid, r_valid, s2_valid;
  logic [SQ_WIDTH-1:0]       f_rad, r_rad;
  logic                      f_ovf;
  logic                      s1_ovf;
  front_side_t               f_side, s1_side;
  logic [$bits(front_side_t)-1:0] s1_side_bits;
  rim_side_t                 r_side, s2_side;
  logic [$bits(rim_side_t)-1:0]   s2_side_bits;
  logic [DIST_WIDTH-1:0]     root1, root2;

  assign busy = 1'b0;

  cpdc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpdc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .item      (query),
    .cfg       (cfg),
    .out_valid (f_valid),
    .radicand  (f_rad),
    .ovf       (f_ovf),
    .side      (f_side)
  );

  // radial length, with the overflow flag carried along so the rim stage saturates the excess
  cpdc_sqrt #(.W(SQ_WIDTH), .SIDE($bits(front_side_t) + 1)) u_sqrt_radial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .radicand  (f_rad),
    .side_in   ({f_side, f_ovf}),
    .out_valid (s1_valid),
    .root      (root1),
    .side_out  ({s1_side_bits, s1_ovf})
  );

  assign s1_side = front_side_t'(s1_side_bits);

  cpdc_rim u_rim (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s1_valid),
    .root       (root1),
    .ovf        (s1_ovf),
    .side_in    (s1_side),
    .cyl_radius (cfg.cyl_radius),
    .out_valid  (r_valid),
    .radicand   (r_rad),
    .side_out   (r_side)
  );

  cpdc_sqrt #(.W(SQ_WIDTH), .SIDE($bits(rim_side_t))) u_sqrt_rim (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .radicand  (r_rad),
    .side_in   (r_side),
    .out_valid (s2_valid),
    .root      (root2),
    .side_out  (s2_side_bits)
  );

  assign s2_side = rim_side_t'(s2_side_bits);

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
  end

  // result transaction payload
  always_ff @(posedge clk) begin
    if (s2_side.rim) begin
      result.signed_dist <= root2[DIST_WIDTH-1] ? DMAX : root2;
    end else begin
      result.signed_dist <= s2_side.mx;
    end
    result.is_inside   <= s2_side.inner;
    result.is_outside  <= s2_side.outside;
    result.is_boundary <= !s2_side.inner && !s2_side.outside;
  end

endmodule

[src/cpdc_regs.sv]
// configuration register file with apb-style access
module cpdc_regs import cpdc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [REG_ADDR_WIDTH-1:0] paddr,
  input  logic [REG_DATA_WIDTH-1:0] pwdata,
  output logic [REG_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[REG_ADDR_WIDTH-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_x     <= '0;
      cfg.base_y     <= '0;
      cfg.base_z     <= '0;
      cfg.axis_x     <= '0;
      cfg.axis_y     <= '0;
      cfg.axis_z     <= AXIS_WIDTH'(1 << FRAC_BITS);
      cfg.cyl_radius <= LEN_WIDTH'(1 << FRAC_BITS);
      cfg.cyl_height <= LEN_WIDTH'(1 << FRAC_BITS);
    end else if (wr_en) begin
      unique case (idx)
        REG_BASE_X:     cfg.base_x     <= pwdata[COORD_WIDTH-1:0];
        REG_BASE_Y:     cfg.base_y     <= pwdata[COORD_WIDTH-1:0];
        REG_BASE_Z:     cfg.base_z     <= pwdata[COORD_WIDTH-1:0];
        REG_AXIS_X:     cfg.axis_x     <= pwdata[AXIS_WIDTH-1:0];
        REG_AXIS_Y:     cfg.axis_y     <= pwdata[AXIS_WIDTH-1:0];
        REG_AXIS_Z:     cfg.axis_z     <= pwdata[AXIS_WIDTH-1:0];
        REG_CYL_RADIUS: cfg.cyl_radius <= pwdata[LEN_WIDTH-1:0];
        REG_CYL_HEIGHT: cfg.cyl_height <= pwdata[LEN_WIDTH-1:0];
      endcase
    end
  end

  // read mux, signed registers sign extended
  always_comb begin
    unique case (idx)
      REG_BASE_X:     prdata = REG_DATA_WIDTH'(cfg.base_x);
      REG_BASE_Y:     prdata = REG_DATA_WIDTH'(cfg.base_y);
      REG_BASE_Z:     prdata = REG_DATA_WIDTH'(cfg.base_z);
      REG_AXIS_X:     prdata = {{(REG_DATA_WIDTH-AXIS_WIDTH){cfg.axis_x[AXIS_WIDTH-1]}},
                                cfg.axis_x};
      REG_AXIS_Y:     prdata = {{(REG_DATA_WIDTH-AXIS_WIDTH){cfg.axis_y[AXIS_WIDTH-1]}},
                                cfg.axis_y};
      REG_AXIS_Z:     prdata = {{(REG_DATA_WIDTH-AXIS_WIDTH){cfg.axis_z[AXIS_WIDTH-1]}},
                                cfg.axis_z};
      REG_CYL_RADIUS: prdata = {{(REG_DATA_WIDTH-LEN_WIDTH){1'b0}}, cfg.cyl_radius};
      REG_CYL_HEIGHT: prdata = {{(REG_DATA_WIDTH-LEN_WIDTH){1'b0}}, cfg.cyl_height};
    endcase
  end

endmodule

[src/cpdc_front.sv]
// front pipeline: axial distance, radial squares and band classification
module cpdc_front import cpdc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  in_item_t            item,
  input  cfg_t                cfg,
  output logic                out_valid,
  output logic [SQ_WIDTH-1:0] radicand,
  output logic                ovf,
  output front_side_t         side
);

  localparam int NSTG = 10;

  logic signed [COORD_WIDTH-1:0] pt [3];
  logic signed [COORD_WIDTH-1:0] bs [3];
  logic signed [AXIS_WIDTH-1:0]  ax [3];

  logic [NSTG:1] vld;

  // stage registers
  logic signed [V_W-1:0]   v1 [3], v2 [3], v3 [3], v4 [3];
  logic [LEN_WIDTH-1:0]    t1, t2, t3, t4;
  logic signed [V_W-1:0]   rm1;
  logic [LEN_WIDTH:0]      rp1;
  logic signed [P_W-1:0]   p2 [3];
  logic                    rmok2, rmok3, rmok4, rmok5, rmok6, rmok7, rmok8, rmok9;
  logic [SQ_WIDTH-1:0]     rmsq2, rmsq3, rmsq4, rmsq5, rmsq6, rmsq7, rmsq8, rmsq9;
  logic [SQ_WIDTH-1:0]     rpsq2, rpsq3, rpsq4, rpsq5, rpsq6, rpsq7, rpsq8, rpsq9;
  logic signed [D1_W-1:0]  d1_3, d1_4;
  logic signed [Q_W-1:0]   pr4 [3];
  logic signed [PD_W-1:0]  d2_4;
  logic signed [R_W-1:0]   r5 [3];
  logic                    ind5, ind6, ind7, ind8, ind9;
  logic                    outd5, outd6, outd7, outd8, outd9;
  logic signed [PD_W-1:0]  pd5, pd6, pd7, pd8, pd9;
  logic [R_W-1:0]          mag6 [3];
  logic [2*RH_W-1:0]       hh7 [3], hl7 [3], ll7 [3];
  logic [SQ1_W-1:0]        sq8 [3];
  logic [RSQ_W-1:0]        rsq9;

  // combinational helpers
  logic signed [P_W+1:0]   dot3;
  logic signed [PD_W-1:0]  tt4, d1x4;

  always_comb begin
    pt[0] = item.point_x; pt[1] = item.point_y; pt[2] = item.point_z;
    bs[0] = cfg.base_x;   bs[1] = cfg.base_y;   bs[2] = cfg.base_z;
    ax[0] = cfg.axis_x;   ax[1] = cfg.axis_y;   ax[2] = cfg.axis_z;
  end

  assign dot3 = (P_W+2)'(p2[0]) + (P_W+2)'(p2[1]) + (P_W+2)'(p2[2]);
  assign tt4  = $signed({{(PD_W-LEN_WIDTH){1'b0}}, t4});
  assign d1x4 = $signed({{(PD_W-D1_W){d1_4[D1_W-1]}}, d1_4});

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTG-1:1], in_valid};
    end
  end

  // stage 1: offset from base, band radii
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      v1[i] <= $signed({pt[i][COORD_WIDTH-1], pt[i]}) - $signed({bs[i][COORD_WIDTH-1], bs[i]});
    end
    t1  <= item.half_thick;
    rm1 <= $signed({2'b00, cfg.cyl_radius}) - $signed({2'b00, item.half_thick});
    rp1 <= {1'b0, cfg.cyl_radius} + {1'b0, item.half_thick};
  end

  // stage 2: axial products, band radius squares
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p2[i] <= v1[i] * ax[i];
    end
    v2    <= v1;
    t2    <= t1;
    rmok2 <= !rm1[V_W-1];
    rmsq2 <= SQ_WIDTH'(rm1[LEN_WIDTH-1:0]) * SQ_WIDTH'(rm1[LEN_WIDTH-1:0]);
    rpsq2 <= SQ_WIDTH'(rp1) * SQ_WIDTH'(rp1);
  end

  // stage 3: dot product, floor shift to axial distance
  always_ff @(posedge clk) begin
    d1_3  <= dot3[P_W+1:FRAC_BITS];
    v3    <= v2;
    t3    <= t2;
    rmok3 <= rmok2;
    rmsq3 <= rmsq2;
    rpsq3 <= rpsq2;
  end

  // stage 4: projection products, far cap distance
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pr4[i] <= d1_3 * ax[i];
    end
    d2_4  <= -$signed({{(PD_W-LEN_WIDTH){1'b0}}, cfg.cyl_height})
             - $signed({d1_3[D1_W-1], d1_3});
    d1_4  <= d1_3;
    v4    <= v3;
    t4    <= t3;
    rmok4 <= rmok3;
    rmsq4 <= rmsq3;
    rpsq4 <= rpsq3;
  end

  // stage 5: radial components, cap tests
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      r5[i] <= $signed({{(R_W-V_W){v4[i][V_W-1]}}, v4[i]})
               - $signed({pr4[i][Q_W-1], pr4[i][Q_W-1:FRAC_BITS]});
    end
    ind5  <= (d1x4 <= -tt4) && (d2_4 <= -tt4);
    outd5 <= (d1x4 > tt4) || (d2_4 > tt4);
    pd5   <= (d1x4 > d2_4) ? d1x4 : d2_4;
    rmok5 <= rmok4;
    rmsq5 <= rmsq4;
    rpsq5 <= rpsq4;
  end

  // stage 6: magnitudes
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag6[i] <= r5[i][R_W-1] ? R_W'(-r5[i]) : R_W'(r5[i]);
    end
    ind6  <= ind5;
    outd6 <= outd5;
    pd6   <= pd5;
    rmok6 <= rmok5;
    rmsq6 <= rmsq5;
    rpsq6 <= rpsq5;
  end

  // stage 7: partial products of the squares
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      hh7[i] <= (2*RH_W)'(mag6[i][R_W-1:RH_W]) * (2*RH_W)'(mag6[i][R_W-1:RH_W]);
      hl7[i] <= (2*RH_W)'(mag6[i][R_W-1:RH_W]) * (2*RH_W)'(mag6[i][RH_W-1:0]);
      ll7[i] <= (2*RH_W)'(mag6[i][RH_W-1:0]) * (2*RH_W)'(mag6[i][RH_W-1:0]);
    end
    ind7  <= ind6;
    outd7 <= outd6;
    pd7   <= pd6;
    rmok7 <= rmok6;
    rmsq7 <= rmsq6;
    rpsq7 <= rpsq6;
  end

  // stage 8: assemble each square
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq8[i] <= (SQ1_W'(hh7[i]) << (2*RH_W)) + (SQ1_W'(hl7[i]) << (RH_W+1))
                + SQ1_W'(ll7[i]);
    end
    ind8  <= ind7;
    outd8 <= outd7;
    pd8   <= pd7;
    rmok8 <= rmok7;
    rmsq8 <= rmsq7;
    rpsq8 <= rpsq7;
  end

  // stage 9: radial square sum
  always_ff @(posedge clk) begin
    rsq9  <= RSQ_W'(sq8[0]) + RSQ_W'(sq8[1]) + RSQ_W'(sq8[2]);
    ind9  <= ind8;
    outd9 <= outd8;
    pd9   <= pd8;
    rmok9 <= rmok8;
    rmsq9 <= rmsq8;
    rpsq9 <= rpsq8;
  end

  // stage 10: radial band tests, radicand for the root
  always_ff @(posedge clk) begin
    side.inner   <= ind9 && rmok9 && (rsq9 <= RSQ_W'(rmsq9));
    side.outside <= outd9 || (rsq9 >= RSQ_W'(rpsq9));
    side.pd      <= pd9;
    ovf          <= |rsq9[RSQ_W-1:SQ_WIDTH];
    radicand     <= rsq9[SQ_WIDTH-1:0];
  end

  assign out_valid = vld[NSTG];

endmodule

[src/cpdc_sqrt.sv]
// pipelined integer square root, one root bit per stage
module cpdc_sqrt import cpdc_pkg::*; #(
  parameter int W    = SQ_WIDTH,
  parameter int SIDE = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [W-1:0]     radicand,
  input  logic [SIDE-1:0]  side_in,
  output logic             out_valid,
  output logic [W/2-1:0]   root,
  output logic [SIDE-1:0]  side_out
);

  localparam int H = W / 2;

  logic [H:1]      vld;
  logic [W-1:0]    rad [1:H];
  logic [H+1:0]    rem [1:H];
  logic [H-1:0]    rt  [1:H];
  logic [SIDE-1:0] sd  [1:H];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[H-1:1], in_valid};
    end
  end

  for (genvar k = 0; k < H; k++) begin : g_stage
    logic [W-1:0]    rad_i;
    logic [H+1:0]    rem_i;
    logic [H-1:0]    rt_i;
    logic [SIDE-1:0] sd_i;
    logic [H+3:0]    cur;
    logic [H+3:0]    trial;
    logic            take;

    if (k == 0) begin : g_first
      assign rad_i = radicand;
      assign rem_i = '0;
      assign rt_i  = '0;
      assign sd_i  = side_in;
    end else begin : g_next
      assign rad_i = rad[k];
      assign rem_i = rem[k];
      assign rt_i  = rt[k];
      assign sd_i  = sd[k];
    end

    // trial subtract of the next radicand bit pair
    assign cur   = {rem_i, rad_i[W-1:W-2]};
    assign trial = {2'b00, rt_i, 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      rad[k+1] <= {rad_i[W-3:0], 2'b00};
      rem[k+1] <= take ? (H+2)'(cur - trial) : cur[H+1:0];
      rt[k+1]  <= {rt_i[H-2:0], take};
      sd[k+1]  <= sd_i;
    end
  end

  assign out_valid = vld[H];
  assign root      = rt[H];
  assign side_out  = sd[H];

endmodule

[src/cpdc_rim.sv]
// radial excess, rim selection and rim radicand
module cpdc_rim import cpdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [DIST_WIDTH-1:0] root,
  input  logic                  ovf,
  input  front_side_t           side_in,
  input  logic [LEN_WIDTH-1:0]  cyl_radius,
  output logic                  out_valid,
  output logic [SQ_WIDTH-1:0]   radicand,
  output rim_side_t             side_out
);

  localparam logic signed [CYL_W-1:0] CYL_LIM = CYL_W'(64'd1 << (DIST_WIDTH-1));
  localparam logic signed [PD_W-1:0]  PD_LIM  = PD_W'(64'd1 << (DIST_WIDTH-1));
  localparam logic signed [PD_W-1:0]  DMAX    = PD_W'((64'd1 << (DIST_WIDTH-1)) - 64'd1);

  logic [3:1] vld;

  logic signed [CYL_W-1:0] cylw;
  logic signed [CYL_W-1:0] cyla;
  logic signed [PD_W-1:0]  pda;
  logic                    ina, outa, inb, outb;
  logic signed [PD_W-1:0]  cylx, mxw;
  logic                    rimb;
  logic signed [DIST_WIDTH-1:0] mxb;
  logic [SQ_WIDTH-1:0]     csqb, psqb;

  assign cylw = $signed({2'b00, root}) - $signed({3'b000, cyl_radius});
  assign cylx = $signed({{(PD_W-CYL_W){cyla[CYL_W-1]}}, cyla});
  assign mxw  = (cylx > pda) ? cylx : pda;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:1], in_valid};
    end
  end

  // stage a: excesses clamped where the distance saturates anyway
  always_ff @(posedge clk) begin
    cyla <= (ovf || (cylw > CYL_LIM)) ? CYL_LIM : cylw;
    pda  <= (side_in.pd > PD_LIM) ? PD_LIM : side_in.pd;
    ina  <= side_in.inner;
    outa <= side_in.outside;
  end

  // stage b: squares for the rim, larger excess elsewhere
  always_ff @(posedge clk) begin
    rimb <= (cyla > 0) && (pda > 0);
    csqb <= SQ_WIDTH'(cyla[DIST_WIDTH-1:0]) * SQ_WIDTH'(cyla[DIST_WIDTH-1:0]);
    psqb <= SQ_WIDTH'(pda[DIST_WIDTH-1:0]) * SQ_WIDTH'(pda[DIST_WIDTH-1:0]);
    mxb  <= (mxw > DMAX) ? DMAX[DIST_WIDTH-1:0] : mxw[DIST_WIDTH-1:0];
    inb  <= ina;
    outb <= outa;
  end

  // stage c: rim radicand
  always_ff @(posedge clk) begin
    radicand         <= csqb + psqb;
    side_out.rim     <= rimb;
    side_out.mx      <= mxb;
    side_out.inner   <= inb;
    side_out.outside <= outb;
  end

  assign out_valid = vld[3];

endmodule

[verif/tb_top.sv]
// testbench for the capped cylinder signed distance and band classifier
module tb_top;
  import cpdc_pkg::*;

  localparam longint SAT_LIM = 64'sd1 << 62;
  localparam int     IDLE_LIMIT = 1000;
  localparam int     DRAIN_CYCLES = 100;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  in_item_t                  query;
  logic                      done;
  out_item_t                 result;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [REG_ADDR_WIDTH-1:0] paddr;
  logic [REG_DATA_WIDTH-1:0] pwdata;
  logic [REG_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  cfg_t      cyl_cfg;
  out_item_t expected_results[$];
  int        mismatches;
  int        queries_sent;
  int        results_seen;
  int        config_writes;
  int        idle_pct;
  int        quiet_cycles;

  cylinder_point_distance_classify u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .query(query),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // saturation of wide intermediates to +-2^62
  function automatic longint sat_wide(logic signed [127:0] x);
    if (x > SAT_LIM) return SAT_LIM;
    if (x < -SAT_LIM) return -SAT_LIM;
    return longint'(x);
  endfunction

  // floor square root of a 128-bit radicand
  function automatic longint floor_root(logic [127:0] n);
    logic [63:0]  root;
    logic [63:0]  cand;
    logic [127:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      sq = {64'd0, cand} * {64'd0, cand};
      if (sq <= n) root = cand;
    end
    return longint'(root);
  endfunction

  // expected distance and flags for one point against the current cylinder
  function automatic out_item_t predict_cylinder(in_item_t q);
    longint             v[3];
    longint             ax[3];
    longint             d1, d2, pd, cyl, dval, th, rad, hgt, rc, pr;
    logic signed [127:0] wa, wb, dot, rsum;
    logic [127:0]        rsq, band;
    logic                ins, outs;
    out_item_t           r;
    v[0] = longint'(signed'(q.point_x)) - longint'(signed'(cyl_cfg.base_x));
    v[1] = longint'(signed'(q.point_y)) - longint'(signed'(cyl_cfg.base_y));
    v[2] = longint'(signed'(q.point_z)) - longint'(signed'(cyl_cfg.base_z));
    ax[0] = longint'(signed'(cyl_cfg.axis_x));
    ax[1] = longint'(signed'(cyl_cfg.axis_y));
    ax[2] = longint'(signed'(cyl_cfg.axis_z));
    rad = longint'({1'b0, cyl_cfg.cyl_radius});
    hgt = longint'({1'b0, cyl_cfg.cyl_height});
    th  = longint'({1'b0, q.half_thick});
    // axial distance
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      wa = v[i];
      wb = ax[i];
      dot = dot + wa * wb;
    end
    d1 = sat_wide(dot >>> FRAC_BITS);
    // radial vector and its squared length
    rsum = '0;
    for (int i = 0; i < 3; i++) begin
      wa = d1;
      wb = ax[i];
      pr = sat_wide((wa * wb) >>> FRAC_BITS);
      wa = v[i] - pr;
      rc = sat_wide(wa);
      wa = rc;
      rsum = rsum + wa * wa;
    end
    rsq = rsum;
    wa = floor_root(rsq) - rad;
    cyl = sat_wide(wa);
    d2 = -hgt - d1;
    wa = (d1 > d2) ? d1 : d2;
    pd = sat_wide(wa);
    // rim region uses the combined excess, elsewhere the larger one
    if (cyl > 0 && pd > 0) begin
      wa = cyl;
      wb = pd;
      dval = floor_root(wa * wa + wb * wb);
    end else begin
      dval = (cyl > pd) ? cyl : pd;
    end
    if (dval > 64'sd2147483647) dval = 64'sd2147483647;
    if (dval < -64'sd2147483648) dval = -64'sd2147483648;
    ins = 1'b0;
    if (d1 <= -th && d2 <= -th && rad >= th) begin
      wa = rad - th;
      band = wa * wa;
      ins = (rsq <= band);
    end
    wa = rad + th;
    band = wa * wa;
    outs = (d1 > th) || (d2 > th) || (rsq >= band);
    r.signed_dist = dval[31:0];
    r.is_inside   = ins;
    r.is_outside  = outs;
    r.is_boundary = !ins && !outs;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h (result %0d)", field, got, want,
             results_seen);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", result.signed_dist, '0);
      end else begin
        want = expected_results.pop_front();
        if (result.signed_dist !== want.signed_dist)
          report_mismatch("signed_dist", result.signed_dist, want.signed_dist);
        if (result.is_inside !== want.is_inside)
          report_mismatch("is_inside", 32'(result.is_inside), 32'(want.is_inside));
        if (result.is_outside !== want.is_outside)
          report_mismatch("is_outside", 32'(result.is_outside), 32'(want.is_outside));
        if (result.is_boundary !== want.is_boundary)
          report_mismatch("is_boundary", 32'(result.is_boundary), 32'(want.is_boundary));
      end
      results_seen++;
    end
  end

  // watchdog on cycles with no accepted transaction
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one apb write, mirrored into the local copy of the configuration
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REG_ADDR_WIDTH'({idx, 2'b00});
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_BASE_X:     cyl_cfg.base_x = val;
      REG_BASE_Y:     cyl_cfg.base_y = val;
      REG_BASE_Z:     cyl_cfg.base_z = val;
      REG_AXIS_X:     cyl_cfg.axis_x = val[AXIS_WIDTH-1:0];
      REG_AXIS_Y:     cyl_cfg.axis_y = val[AXIS_WIDTH-1:0];
      REG_AXIS_Z:     cyl_cfg.axis_z = val[AXIS_WIDTH-1:0];
      REG_CYL_RADIUS: cyl_cfg.cyl_radius = val[LEN_WIDTH-1:0];
      REG_CYL_HEIGHT: cyl_cfg.cyl_height = val[LEN_WIDTH-1:0];
      default: ;
    endcase
    config_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_cylinder(int bx, int by, int bz, int axx, int axy, int axz,
                              int unsigned rad, int unsigned hgt);
    write_reg(REG_BASE_X, bx);
    write_reg(REG_BASE_Y, by);
    write_reg(REG_BASE_Z, bz);
    write_reg(REG_AXIS_X, axx);
    write_reg(REG_AXIS_Y, axy);
    write_reg(REG_AXIS_Z, axz);
    write_reg(REG_CYL_RADIUS, rad);
    write_reg(REG_CYL_HEIGHT, hgt);
  endtask

  // send one query transaction, at times with a random gap ahead of it
  task automatic send_query(int px, int py, int pz, int unsigned th);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    query.point_x    = px;
    query.point_y    = py;
    query.point_z    = pz;
    query.half_thick = th[LEN_WIDTH-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(predict_cylinder(query));
    queries_sent++;
  endtask

  // wait until every expected result is back and the pipeline is empty
  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // unit cylinder after reset: center, surfaces, rim, band and extremes
  task automatic test_reset_cylinder;
    idle_pct = 0;
    send_query(0, 0, -32768, 0);
    send_query(65536, 0, -32768, 0);            // exactly on the side wall
    send_query(65536, 0, -32768, 4096);
    send_query(0, 0, 0, 0);                      // on the top cap
    send_query(0, 0, -65536, 0);                 // on the bottom cap
    send_query(131072, 0, 65536, 0);             // rim region
    send_query(0, 0, -32768, 32'h7fffffff);      // band wider than radius
    send_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    send_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_query(32'h80000000, 32'h7fffffff, 0, 65536);
    send_query(100, -200, -300, 1);
    drain();
  endtask

  // non-unit and extreme axis, saturating extents
  task automatic test_extreme_cylinder;
    set_cylinder(32'h7fffffff, 32'h80000000, 0, -131072, 131071, 65536,
                 32'h7fffffff, 32'h7fffffff);
    idle_pct = 50;
    send_query(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
    send_query(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff);
    send_query(0, 0, 0, 12345);
    send_query(32'h80000000, 32'h80000000, 32'h80000000, 0);
    drain();
    set_cylinder(0, 0, 0, 65536, 0, 0, 0, 0);    // degenerate cylinder on x
    send_query(0, 0, 0, 0);
    send_query(65536, 0, 0, 0);
    send_query(-1, 1, 0, 1);
    send_query(0, 32'h7fffffff, 32'h80000000, 0);
    drain();
  endtask

  function automatic int near_coord(int c, int span);
    return c + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // random cylinders with points clustered around them plus random noise
  task automatic test_random_queries(int total);
    int          span;
    int unsigned th;
    int          sel;
    int          ax[3];
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 36 : (ph < 4) ? 69 : 0;
      sel = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) ax[i] = 0;
      if (sel == 0) begin
        ax[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 65536 : -65536;
      end else if (sel == 3) begin
        for (int i = 0; i < 3; i++) ax[i] = $signed($urandom_range(0, 262143)) - 131072;
      end else begin
        for (int i = 0; i < 3; i++) ax[i] = $signed($urandom_range(0, 131072)) - 65536;
      end
      drain();
      set_cylinder($urandom_range(0, 1) ? $urandom : near_coord(0, 1 << 20),
                   $urandom_range(0, 1) ? $urandom : near_coord(0, 1 << 20),
                   $urandom_range(0, 1) ? $urandom : near_coord(0, 1 << 20),
                   ax[0], ax[1], ax[2],
                   (ph == 5) ? $urandom >> 1 : $urandom_range(0, 8 << 16),
                   (ph == 5) ? $urandom >> 1 : $urandom_range(0, 8 << 16));
      span = (ph == 5) ? 32'h40000000 : (12 << 16);
      for (int n = 0; n < total / 6; n++) begin
        case ($urandom_range(0, 3))
          0:       th = 0;
          1:       th = $urandom_range(0, 1 << 16);
          2:       th = $urandom_range(0, 4 << 16);
          default: th = $urandom >> 1;
        endcase
        if ($urandom_range(0, 4) == 0)
          send_query($urandom, $urandom, $urandom, th);
        else
          send_query(near_coord(cyl_cfg.base_x, span), near_coord(cyl_cfg.base_y, span),
                     near_coord(cyl_cfg.base_z, span), th);
      end
    end
    drain();
  endtask

  // stimulus
  initial begin
    rst = 1'b1;
    start = 1'b0;
    query = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    queries_sent = 0;
    results_seen = 0;
    config_writes = 0;
    idle_pct = 0;
    quiet_cycles = 0;
    cyl_cfg = '0;
    cyl_cfg.axis_z = 18'sd65536;
    cyl_cfg.cyl_radius = 31'd65536;
    cyl_cfg.cyl_height = 31'd65536;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_cylinder();
    test_extreme_cylinder();
    test_random_queries(1250);

    $display("covered %0d queries, %0d results, %0d register writes",
             queries_sent, results_seen, config_writes);
    $display("cylinders: reset default, extreme axis and extents, six random setups");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
